FILE: hw/rtl/tmcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcr_pkg
// Shared constants, codes, item types and helpers of the text-mode cell
// renderer.
// ----------------------------------------------------------------------------
package tmcr_pkg;

  localparam int TEXT_COLUMNS = 80;
  localparam int TEXT_LINES   = 25;
  localparam int GLYPH_HEIGHT = 14;

  localparam int TEXT_DEPTH = TEXT_COLUMNS * TEXT_LINES;
  localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
  localparam int FONT_DEPTH = 256 * GLYPH_HEIGHT;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);
  localparam int PAL_DEPTH  = 16;
  localparam int PAL_AW     = $clog2(PAL_DEPTH);
  localparam int ROW_W      = $clog2(GLYPH_HEIGHT);

  localparam logic [7:0] MASK_FULL = 8'hFF;
  localparam logic [7:0] MASK_BOX  = 8'h81;

  typedef enum logic [2:0] {
    CMD_WRITE_CELL  = 3'd0,
    CMD_FONT_ROW    = 3'd1,
    CMD_PALETTE     = 3'd2,
    CMD_RENDER      = 3'd3,
    CMD_CURSOR_MOVE = 3'd4,
    CMD_BLINK       = 3'd5,
    CMD_FOCUS_GAIN  = 3'd6,
    CMD_FOCUS_LOST  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_HIDDEN   = 2'd0,
    MODE_VISIBLE  = 2'd1,
    MODE_INACTIVE = 2'd2
  } cursor_mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_FORE,
    ST_BACK,
    ST_ROWS
  } state_t;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] column;
    logic [4:0] line;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [3:0] glyph_line;
    logic [7:0] glyph_bits;
    logic [3:0] palette_index;
    logic [5:0] palette_red;
    logic [5:0] palette_green;
    logic [5:0] palette_blue;
  } item_t;

  typedef struct packed {
    logic [3:0]  pixel_row;
    logic [7:0]  pixel_mask;
    logic [23:0] fore_rgb;
    logic [23:0] back_rgb;
    logic        last_row;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic text_we;
    logic font_we;
    logic pal_we;
    logic render_start;
    logic cur_move;
    logic cur_blink;
    logic cur_focus;
    logic cur_unfocus;
    logic cell_ld;
    logic fore_ld;
    logic back_ld;
    logic row_ld;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic in_grid;
    logic gline_ok;
    logic clr_last;
    logic row_last;
  } dp_stat_t;

  // v*255/63 rounded down equals 4v + v/21
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [1:0] q;
    q = (v == 6'd63) ? 2'd3 : (v >= 6'd42) ? 2'd2 : (v >= 6'd21) ? 2'd1 : 2'd0;
    return {v, 2'b00} + {6'd0, q};
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tmcr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcr_in_if / tmcr_out_if
// Valid/ready channels for command items and rendered row items.
// ----------------------------------------------------------------------------
interface tmcr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [6:0] column;
  logic [4:0] line;
  logic [7:0] char_code;
  logic [7:0] attribute;
  logic [3:0] glyph_line;
  logic [7:0] glyph_bits;
  logic [3:0] palette_index;
  logic [5:0] palette_red;
  logic [5:0] palette_green;
  logic [5:0] palette_blue;

  modport source (
    output valid, command, column, line, char_code, attribute, glyph_line,
           glyph_bits, palette_index, palette_red, palette_green, palette_blue,
    input  ready
  );
  modport sink (
    input  valid, command, column, line, char_code, attribute, glyph_line,
           glyph_bits, palette_index, palette_red, palette_green, palette_blue,
    output ready
  );
endinterface

interface tmcr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  pixel_row;
  logic [7:0]  pixel_mask;
  logic [23:0] fore_rgb;
  logic [23:0] back_rgb;
  logic        last_row;

  modport source (
    output valid, pixel_row, pixel_mask, fore_rgb, back_rgb, last_row,
    input  ready
  );
  modport sink (
    input  valid, pixel_row, pixel_mask, fore_rgb, back_rgb, last_row,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/tmcr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcr_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tmcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tmcr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcr_ctrl
// Sequencer: clearing pass, command dispatch, render steps, result valid.
// ----------------------------------------------------------------------------
module tmcr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire tmcr_pkg::dp_stat_t  stat,
  output tmcr_pkg::ctrl_cmd_t      cmd
);
  import tmcr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign can_load  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (stat.cmd)
            CMD_WRITE_CELL:  cmd.text_we     = stat.in_grid;
            CMD_FONT_ROW:    cmd.font_we     = stat.gline_ok;
            CMD_PALETTE:     cmd.pal_we      = 1'b1;
            CMD_RENDER: begin
              if (stat.in_grid) begin
                cmd.render_start = 1'b1;
                state_nxt        = ST_CELL;
              end
            end
            CMD_CURSOR_MOVE: cmd.cur_move    = 1'b1;
            CMD_BLINK:       cmd.cur_blink   = 1'b1;
            CMD_FOCUS_GAIN:  cmd.cur_focus   = 1'b1;
            CMD_FOCUS_LOST:  cmd.cur_unfocus = 1'b1;
            default: ;
          endcase
        end
      end
      ST_CELL: begin
        cmd.cell_ld = 1'b1;
        state_nxt   = ST_FORE;
      end
      ST_FORE: begin
        cmd.fore_ld = 1'b1;
        state_nxt   = ST_BACK;
      end
      ST_BACK: begin
        cmd.back_ld = 1'b1;
        state_nxt   = ST_ROWS;
      end
      ST_ROWS: begin
        if (can_load) begin
          cmd.row_ld = 1'b1;
          if (stat.row_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.row_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tmcr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcr_dp
// Datapath: text, font and palette RAMs, cursor registers, result register.
// ----------------------------------------------------------------------------
module tmcr_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tmcr_pkg::item_t      item,
  input  wire tmcr_pkg::ctrl_cmd_t  cmd,
  output tmcr_pkg::dp_stat_t        stat,
  output tmcr_pkg::result_t         result
);
  import tmcr_pkg::*;

  // cursor
  logic [6:0]   cur_col_r;
  logic [4:0]   cur_line_r;
  cursor_mode_t cur_mode_r, cur_mode_nxt;
  logic         at_cur_r;

  // render working registers
  logic [15:0]      cell_r;
  logic [23:0]      fore_r;
  logic [23:0]      back_r;
  logic [ROW_W-1:0] row_r;
  logic [TEXT_AW-1:0] clr_addr_r;
  result_t          res_r;

  // RAM ports
  logic               t_we, t_re;
  logic [TEXT_AW-1:0] t_waddr, cell_addr;
  logic [15:0]        t_wdata, t_rdata;
  logic [FONT_AW-1:0] f_waddr, f_raddr;
  logic               f_re;
  logic [7:0]         f_rdata;
  logic [ROW_W-1:0]   row_sel;
  logic               p_re;
  logic [PAL_AW-1:0]  p_raddr;
  logic [23:0]        p_wdata, p_rdata;
  logic [7:0]         mask;

  assign cell_addr = TEXT_AW'(32'(item.line) * TEXT_COLUMNS + 32'(item.column));

  assign stat.cmd      = cmd_t'(item.command);
  assign stat.in_grid  = (32'(item.column) < TEXT_COLUMNS) && (32'(item.line) < TEXT_LINES);
  assign stat.gline_ok = 32'(item.glyph_line) < GLYPH_HEIGHT;
  assign stat.clr_last = clr_addr_r == TEXT_AW'(TEXT_DEPTH - 1);
  assign stat.row_last = row_r == ROW_W'(GLYPH_HEIGHT - 1);

  // text store: clearing pass shares the write port with cell writes
  assign t_we    = cmd.clr_step || cmd.text_we;
  assign t_waddr = cmd.clr_step ? clr_addr_r : cell_addr;
  assign t_wdata = cmd.clr_step ? 16'd0 : {item.attribute, item.char_code};
  assign t_re    = cmd.render_start;

  tmcr_ram #(.WIDTH(16), .DEPTH(TEXT_DEPTH)) u_text_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (cell_addr),
    .rdata (t_rdata)
  );

  // font store: row 0 fetched in the back step, next row on each load but the last
  assign f_waddr = FONT_AW'(32'(item.char_code) * GLYPH_HEIGHT + 32'(item.glyph_line));
  assign row_sel = cmd.back_ld ? '0 : ROW_W'(row_r + 1'b1);
  assign f_raddr = FONT_AW'(32'(cell_r[7:0]) * GLYPH_HEIGHT + 32'(row_sel));
  assign f_re    = cmd.back_ld || (cmd.row_ld && !stat.row_last);

  tmcr_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font_ram (
    .clk   (clk),
    .we    (cmd.font_we),
    .waddr (f_waddr),
    .wdata (item.glyph_bits),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // palette: foreground read from the fresh cell word, background one step later
  assign p_wdata = {widen6(item.palette_red), widen6(item.palette_green),
                    widen6(item.palette_blue)};
  assign p_re    = cmd.cell_ld || cmd.fore_ld;
  assign p_raddr = cmd.cell_ld ? t_rdata[11:8] : cell_r[15:12];

  tmcr_ram #(.WIDTH(24), .DEPTH(PAL_DEPTH)) u_pal_ram (
    .clk   (clk),
    .we    (cmd.pal_we),
    .waddr (item.palette_index),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // cursor mode
  always_comb begin
    cur_mode_nxt = cur_mode_r;
    if (cmd.cur_move || cmd.cur_focus) begin
      cur_mode_nxt = MODE_VISIBLE;
    end else if (cmd.cur_unfocus) begin
      cur_mode_nxt = MODE_INACTIVE;
    end else if (cmd.cur_blink) begin
      case (cur_mode_r)
        MODE_HIDDEN:  cur_mode_nxt = MODE_VISIBLE;
        MODE_VISIBLE: cur_mode_nxt = MODE_HIDDEN;
        default:      cur_mode_nxt = cur_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_line_r <= '0;
      cur_mode_r <= MODE_VISIBLE;
      clr_addr_r <= '0;
    end else begin
      cur_mode_r <= cur_mode_nxt;
      if (cmd.cur_move) begin
        cur_col_r  <= item.column;
        cur_line_r <= item.line;
      end
      if (cmd.clr_step) begin
        clr_addr_r <= TEXT_AW'(clr_addr_r + 1'b1);
      end
    end
  end

  // overlay on the glyph row
  always_comb begin
    mask = f_rdata;
    if (at_cur_r) begin
      case (cur_mode_r)
        MODE_VISIBLE:  mask = MASK_FULL;
        MODE_INACTIVE: mask = (row_r == '0 || stat.row_last) ? MASK_FULL : (f_rdata | MASK_BOX);
        default:       mask = f_rdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.render_start) begin
      at_cur_r <= (item.column == cur_col_r) && (item.line == cur_line_r);
    end
    if (cmd.cell_ld) begin
      cell_r <= t_rdata;
    end
    if (cmd.fore_ld) begin
      fore_r <= p_rdata;
    end
    if (cmd.back_ld) begin
      back_r <= p_rdata;
      row_r  <= '0;
    end
    if (cmd.row_ld) begin
      row_r            <= ROW_W'(row_r + 1'b1);
      res_r.pixel_row  <= 4'(row_r);
      res_r.pixel_mask <= mask;
      res_r.fore_rgb   <= fore_r;
      res_r.back_rgb   <= back_r;
      res_r.last_row   <= stat.row_last;
    end
  end

  assign result = res_r;

endmodule
`default_nettype wire

FILE: hw/rtl/text_mode_cell_renderer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_cell_renderer
// Text-mode character generator: cell buffer, font, palette and cursor
// overlay, emitting the glyph rows of one cell per render command.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the 2000-cell text buffer,
// one cell per cycle, and takes no item until it is done. From then on
// every command except render completes in the cycle it is accepted: cell
// writes, font row writes, palette writes (each 6-bit component widened to
// 8 bits as v*255/63) and the cursor commands. A render of an in-grid cell
// walks three setup steps (text buffer read, foreground palette read,
// background palette read) and then streams 14 row items, one per cycle
// while the result side takes them, fed by one font RAM read per row; no
// new item is taken until the last row item has been loaded.
// The last row item may still wait at the output while the next command is
// accepted. A render of an off-grid cell yields no item. Font and palette
// entries read before they are written give undefined colors and masks.
// ----------------------------------------------------------------------------
module text_mode_cell_renderer (
  input  wire logic clk,
  input  wire logic rst_n,
  tmcr_in_if.sink   in_chan,
  tmcr_out_if.source out_chan
);
  import tmcr_pkg::*;

  item_t      item;
  result_t    result;
  ctrl_cmd_t  ctrl_cmd;
  dp_stat_t   dp_stat;
  logic       in_ready;
  logic       out_valid;

  // gather the input fields into one item
  assign item.command       = in_chan.command;
  assign item.column        = in_chan.column;
  assign item.line          = in_chan.line;
  assign item.char_code     = in_chan.char_code;
  assign item.attribute     = in_chan.attribute;
  assign item.glyph_line    = in_chan.glyph_line;
  assign item.glyph_bits    = in_chan.glyph_bits;
  assign item.palette_index = in_chan.palette_index;
  assign item.palette_red   = in_chan.palette_red;
  assign item.palette_green = in_chan.palette_green;
  assign item.palette_blue  = in_chan.palette_blue;

  assign in_chan.ready = in_ready;

  // sequencer: owns the handshakes and steps the datapath
  tmcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  // datapath: stores, cursor state and the row result register
  tmcr_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .cmd    (ctrl_cmd),
    .stat   (dp_stat),
    .result (result)
  );

  // drive the result channel from the output register
  assign out_chan.valid      = out_valid;
  assign out_chan.pixel_row  = result.pixel_row;
  assign out_chan.pixel_mask = result.pixel_mask;
  assign out_chan.fore_rgb   = result.fore_rgb;
  assign out_chan.back_rgb   = result.back_rgb;
  assign out_chan.last_row   = result.last_row;

`ifndef SYNTHESIS
  // never overwrite a row item the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.row_ld |-> (!out_valid || out_chan.ready))
    else $error("row item overwritten before it was taken");

  // datapath steps are mutually exclusive
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl_cmd.clr_step, ctrl_cmd.text_we, ctrl_cmd.font_we, ctrl_cmd.pal_we,
              ctrl_cmd.render_start, ctrl_cmd.cell_ld, ctrl_cmd.fore_ld,
              ctrl_cmd.back_ld, ctrl_cmd.row_ld}))
    else $error("more than one datapath step in a cycle");

  // ready is held low after a reset cycle, as the clearing pass starts
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_chan.ready)
    else $error("item taken during clearing pass");
`endif

endmodule
`default_nettype wire
